/* rtl/core/lhc_pkg.sv */
// Package for the LED hue/saturation/brightness color controller.
// Command and divider-select codes, fixed-point reciprocals, shared structs.
// No dependencies.
package lhc_pkg;

  typedef enum logic [1:0] {
    OP_SET_POWER = 2'd0,
    OP_SET_LEVEL = 2'd1,
    OP_SET_COLOR = 2'd2,
    OP_TOGGLE    = 2'd3
  } op_e;

  // Constant divisor picked for the shared multiply/divide unit
  typedef enum logic [1:0] {
    DIV_RAW    = 2'd0,
    DIV_PCT    = 2'd1,
    DIV_SECTOR = 2'd2
  } div_e;

  localparam int unsigned HueFull   = 360;
  localparam int unsigned RawSpan   = 254;
  localparam int unsigned PctFull   = 100;
  localparam int unsigned SectorDeg = 60;

  localparam int unsigned LevelW = 8;
  localparam int unsigned HueW   = 9;
  localparam int unsigned SatW   = 7;
  localparam int unsigned OperW  = 9;   // multiplier operands
  localparam int unsigned ProdW  = 17;  // every product used stays below 2^17
  localparam int unsigned QuotW  = 9;   // largest quotient is 361
  localparam int unsigned RecipW = 20;

  // q = (p * ceil(2^S / d)) >> S is exact for p < 2^17 when the rounding
  // error of the reciprocal is at most 2^(S-17); S = 25 covers d <= 256.
  localparam int unsigned RecipShift = 25;
  localparam logic [RecipW-1:0] RecipRaw =
    RecipW'((2**RecipShift + RawSpan - 1) / RawSpan);
  localparam logic [RecipW-1:0] RecipPct =
    RecipW'((2**RecipShift + PctFull - 1) / PctFull);
  localparam logic [RecipW-1:0] RecipSector =
    RecipW'((2**RecipShift + SectorDeg - 1) / SectorDeg);

  typedef struct packed {
    logic [LevelW-1:0] mx;
    logic [LevelW-1:0] mn;
    logic [LevelW-1:0] adj;
    logic [2:0]        sect;
  } mix_in_t;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } color_t;

endpackage

/* rtl/core/lhc_ifs.sv */
// Valid/ready channels of the color controller: command in, RGB word out.
// Depends on lhc_pkg.
interface lhc_cmd_if;
  import lhc_pkg::*;
  logic       valid;
  logic       ready;
  op_e        op;
  logic       on_value;
  logic [7:0] level_in;
  logic [7:0] hue_in;
  logic [7:0] sat_in;

  modport source (output valid, op, on_value, level_in, hue_in, sat_in, input ready);
  modport sink   (input valid, op, on_value, level_in, hue_in, sat_in, output ready);
endinterface

interface lhc_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] level_now;
  logic       is_on;

  modport source (output valid, red, green, blue, level_now, is_on, input ready);
  modport sink   (input valid, red, green, blue, level_now, is_on, output ready);
endinterface

/* rtl/core/lhc_muldiv.sv */
// Shared two-stage unit: q = (a * b) / d for d in {254, 100, 60}.
// Stage 1 multiplies, stage 2 divides by a reciprocal multiply. Uses lhc_pkg.
module lhc_muldiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lhc_pkg::OperW-1:0]     a_i,
  input  logic [lhc_pkg::OperW-1:0]     b_i,
  input  lhc_pkg::div_e                 div_i,
  output logic [lhc_pkg::QuotW-1:0]     q_o,
  output logic                          done_o
);
  import lhc_pkg::*;

  localparam int unsigned FullW = ProdW + RecipW;

  logic                v1_q, v2_q;
  logic [ProdW-1:0]    prod_d, prod_q;
  logic [RecipW-1:0]   recip_d, recip_q;
  logic [FullW-1:0]    full;
  logic [QuotW-1:0]    q_d, q_q;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_comb begin
    unique case (div_i)
      DIV_RAW:    recip_d = RecipRaw;
      DIV_PCT:    recip_d = RecipPct;
      DIV_SECTOR: recip_d = RecipSector;
      default:    recip_d = RecipSector;
    endcase
  end

  assign full = FullW'(prod_q) * FullW'(recip_q);
  assign q_d  = full[RecipShift +: QuotW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      prod_q  <= '0;
      recip_q <= '0;
      q_q     <= '0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      if (start_i) begin
        prod_q  <= prod_d;
        recip_q <= recip_d;
      end
      if (v1_q) begin
        q_q <= q_d;
      end
    end
  end

  assign q_o    = q_q;
  assign done_o = v2_q;

endmodule

/* rtl/core/lhc_mix.sv */
// Hue-sector channel mix: places max, min and ramp onto red, green, blue.
// Uses lhc_pkg.
module lhc_mix (
  input  lhc_pkg::mix_in_t mix_i,
  output lhc_pkg::color_t  color_o
);
  import lhc_pkg::*;

  logic [LevelW-1:0] up, down;

  assign up   = LevelW'(mix_i.mn + mix_i.adj);
  assign down = LevelW'(mix_i.mx - mix_i.adj);

  always_comb begin
    unique case (mix_i.sect)
      3'd0: color_o = '{red: mix_i.mx, green: up,       blue: mix_i.mn};
      3'd1: color_o = '{red: down,     green: mix_i.mx, blue: mix_i.mn};
      3'd2: color_o = '{red: mix_i.mn, green: mix_i.mx, blue: up};
      3'd3: color_o = '{red: mix_i.mn, green: down,     blue: mix_i.mx};
      3'd4: color_o = '{red: up,       green: mix_i.mn, blue: mix_i.mx};
      default: color_o = '{red: mix_i.mx, green: mix_i.mn, blue: down};
    endcase
  end

endmodule

/* rtl/core/led_hsb_color_controller.sv */
// LED color controller: power flag, level, hue and saturation to an RGB word.
// Set_power, set_level and toggle take three passes through the shared
// multiply/divide unit plus the output load; set_color takes five passes.
// A command is taken only in idle, so the next one waits for the output load,
// which stalls while the last word is not taken; a set_power that keeps the flag makes no word.
// Reset (async, active low): off, level 255, hue 0, saturation 0, no word.
module led_hsb_color_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  lhc_cmd_if.sink         cmd_i,
  lhc_rgb_if.source       rgb_o
);
  import lhc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_HUE, S_SAT, S_MIN, S_SECT, S_ADJ, S_OUT
  } state_e;

  state_e            state_d, state_q;
  logic              wait_d, wait_q;
  logic              power_d, power_q;
  logic [LevelW-1:0] level_d, level_q;
  logic [HueW-1:0]   hue_d, hue_q;
  logic [SatW-1:0]   sat_d, sat_q;
  logic [7:0]        hraw_d, hraw_q;
  logic [7:0]        sraw_d, sraw_q;
  logic [LevelW-1:0] mx_d, mx_q;
  logic [LevelW-1:0] mn_d, mn_q;
  logic [LevelW-1:0] adj_d, adj_q;
  logic [2:0]        sect_d, sect_q;
  logic [5:0]        rem_d, rem_q;
  logic              out_valid_d, out_valid_q;
  color_t            out_color_d, out_color_q;
  logic [LevelW-1:0] out_level_d, out_level_q;
  logic              out_on_d, out_on_q;

  logic              start;
  logic [OperW-1:0]  opa, opb;
  div_e              dsel;
  logic [QuotW-1:0]  quot;
  logic              done;
  mix_in_t           mix_in;
  color_t            mix_out;

  lhc_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .a_i     (opa),
    .b_i     (opb),
    .div_i   (dsel),
    .q_o     (quot),
    .done_o  (done)
  );

  assign mix_in = '{mx: mx_q, mn: mn_q, adj: adj_q, sect: sect_q};

  lhc_mix u_mix (
    .mix_i   (mix_in),
    .color_o (mix_out)
  );

  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    power_d     = power_q;
    level_d     = level_q;
    hue_d       = hue_q;
    sat_d       = sat_q;
    hraw_d      = hraw_q;
    sraw_d      = sraw_q;
    mx_d        = mx_q;
    mn_d        = mn_q;
    adj_d       = adj_q;
    sect_d      = sect_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !rgb_o.ready;
    out_color_d = out_color_q;
    out_level_d = out_level_q;
    out_on_d    = out_on_q;
    start       = 1'b0;
    opa         = '0;
    opb         = '0;
    dsel        = DIV_RAW;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          unique case (cmd_i.op)
            OP_SET_POWER: begin
              if (cmd_i.on_value != power_q) begin
                power_d = cmd_i.on_value;
                mx_d    = cmd_i.on_value ? level_q : '0;
                state_d = S_MIN;
              end
            end
            OP_SET_LEVEL: begin
              level_d = cmd_i.level_in;
              mx_d    = cmd_i.level_in;
              state_d = S_MIN;
            end
            OP_SET_COLOR: begin
              hraw_d  = cmd_i.hue_in;
              sraw_d  = cmd_i.sat_in;
              mx_d    = level_q;
              state_d = S_HUE;
            end
            default: begin
              power_d = !power_q;
              level_d = power_q ? '0 : '1;
              mx_d    = power_q ? '0 : '1;
              state_d = S_MIN;
            end
          endcase
        end
      end
      S_HUE: begin
        opa    = OperW'(hraw_q);
        opb    = OperW'(HueFull);
        dsel   = DIV_RAW;
        start  = !wait_q;
        wait_d = 1'b1;
        if (done) begin
          wait_d  = 1'b0;
          // raw 254 and 255 scale past a full turn
          hue_d   = (quot >= QuotW'(HueFull)) ? HueW'(quot - QuotW'(HueFull)) : HueW'(quot);
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        opa    = OperW'(sraw_q);
        opb    = OperW'(PctFull);
        dsel   = DIV_RAW;
        start  = !wait_q;
        wait_d = 1'b1;
        if (done) begin
          wait_d  = 1'b0;
          sat_d   = SatW'(quot);
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        opa    = OperW'(mx_q);
        opb    = OperW'(PctFull) - OperW'(sat_q);
        dsel   = DIV_PCT;
        start  = !wait_q;
        wait_d = 1'b1;
        if (done) begin
          wait_d  = 1'b0;
          mn_d    = LevelW'(quot);
          state_d = S_SECT;
        end
      end
      S_SECT: begin
        opa    = OperW'(hue_q);
        opb    = OperW'(1);
        dsel   = DIV_SECTOR;
        start  = !wait_q;
        wait_d = 1'b1;
        if (done) begin
          wait_d  = 1'b0;
          sect_d  = quot[2:0];
          // hue - 60*sector, with 60 = 64 - 4
          rem_d   = 6'(hue_q - ((HueW'(quot) << 6) - (HueW'(quot) << 2)));
          state_d = S_ADJ;
        end
      end
      S_ADJ: begin
        opa    = OperW'(LevelW'(mx_q - mn_q));
        opb    = OperW'(rem_q);
        dsel   = DIV_SECTOR;
        start  = !wait_q;
        wait_d = 1'b1;
        if (done) begin
          wait_d  = 1'b0;
          adj_d   = LevelW'(quot);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || rgb_o.ready) begin
          out_valid_d = 1'b1;
          out_color_d = mix_out;
          out_level_d = level_q;
          out_on_d    = power_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      power_q     <= 1'b0;
      level_q     <= '1;
      hue_q       <= '0;
      sat_q       <= '0;
      hraw_q      <= '0;
      sraw_q      <= '0;
      mx_q        <= '0;
      mn_q        <= '0;
      adj_q       <= '0;
      sect_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_color_q <= '0;
      out_level_q <= '0;
      out_on_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      power_q     <= power_d;
      level_q     <= level_d;
      hue_q       <= hue_d;
      sat_q       <= sat_d;
      hraw_q      <= hraw_d;
      sraw_q      <= sraw_d;
      mx_q        <= mx_d;
      mn_q        <= mn_d;
      adj_q       <= adj_d;
      sect_q      <= sect_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      out_color_q <= out_color_d;
      out_level_q <= out_level_d;
      out_on_q    <= out_on_d;
    end
  end

  assign cmd_i.ready     = (state_q == S_IDLE);
  assign rgb_o.valid     = out_valid_q;
  assign rgb_o.red       = out_color_q.red;
  assign rgb_o.green     = out_color_q.green;
  assign rgb_o.blue      = out_color_q.blue;
  assign rgb_o.level_now = out_level_q;
  assign rgb_o.is_on     = out_on_q;

endmodule
